// ----- rtl/trapezoid_edge_grow_top_defines.svh -----
// Assertion macros used by the port-level checker file of the trapezoid edge grower.
`ifndef TRAPEZOID_EDGE_GROW_TOP_DEFINES_SVH
`define TRAPEZOID_EDGE_GROW_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock and idle in reset.
`define TEG_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("teg check failed");

// Next-cycle implication, sampled on the rising clock and idle in reset.
`define TEG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("teg check failed");

`endif

// ----- rtl/teg_pkg.sv -----
// Package with the types, constants and saturation helpers of the trapezoid edge grower.
`default_nettype none
package teg_pkg;

   localparam int CoordWidth    = 32;
   localparam int GrowWidth     = 30;
   localparam int InfYWidth     = 31;
   localparam int SumWidth      = CoordWidth + 2;
   localparam int MagWidth      = CoordWidth + 1;
   localparam int DivSteps      = MagWidth;
   localparam int DivCountWidth = $clog2(DivSteps + 1);
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 32;

   localparam logic [CsrIndexWidth-1:0] CsrGrowAmount = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrInfY       = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrInfXLeft   = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CsrInfXRight  = 2'd3;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic [MagWidth-1:0] mag_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   localparam coord_type CoordMax = {1'b0, {(CoordWidth-1){1'b1}}};
   localparam coord_type CoordMin = {1'b1, {(CoordWidth-1){1'b0}}};

   // Clamp a widened signed value to the coordinate range.
   function automatic coord_type sat_coord(input logic signed [SumWidth-1:0] v);
      logic [SumWidth-CoordWidth:0] top;
      top = v[SumWidth-1:CoordWidth-1];
      if (&top || ~|top) begin
         return v[CoordWidth-1:0];
      end else if (v[SumWidth-1]) begin
         return CoordMin;
      end else begin
         return CoordMax;
      end
   endfunction

   // Push a coordinate outward by the grow amount, saturating.
   function automatic coord_type grow_coord(input coord_type a,
                                            input logic [GrowWidth-1:0] g,
                                            input logic sub);
      logic signed [SumWidth-1:0] av;
      logic signed [SumWidth-1:0] gv;
      logic signed [SumWidth-1:0] s;
      av = {{(SumWidth-CoordWidth){a[CoordWidth-1]}}, a};
      gv = {{(SumWidth-GrowWidth){1'b0}}, g};
      s  = sub ? (av - gv) : (av + gv);
      return sat_coord(s);
   endfunction

endpackage
`default_nettype wire

// ----- rtl/teg_div.sv -----
// Iterative restoring divider on magnitudes, one quotient bit per cycle.
`default_nettype none
module teg_div (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire teg_pkg::mag_type dividend,
   input  wire teg_pkg::mag_type divisor,
   output teg_pkg::div_stat_type stat,
   output teg_pkg::mag_type   quotient
);
   import teg_pkg::*;

   mag_type                  rem_ff, rem_in;
   mag_type                  quo_ff, quo_in;
   mag_type                  dvs_ff;
   logic [DivCountWidth-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;

   logic [MagWidth:0]   shifted;
   logic [MagWidth+1:0] trial;
   logic                fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[MagWidth-1]};
      trial   = {1'b0, shifted} - {2'b00, dvs_ff};
      fits    = ~trial[MagWidth+1];
      rem_in  = fits ? trial[MagWidth-1:0] : shifted[MagWidth-1:0];
      quo_in  = {quo_ff[MagWidth-2:0], fits};
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DivCountWidth'(DivSteps);
      end else if (busy_ff) begin
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DivCountWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule
`default_nettype wire

// ----- rtl/trapezoid_edge_grow_top.sv -----
// Top level of the trapezoid edge grower: sequencer, bounding box and output register.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_stall  | tile sides and corner y values
//   rsp     | out       | rsp_valid/rsp_stall  | one edge, slope, flags, bounding box
//   csr     | in        | csr_write_en         | csr_index, csr_wdata
//
// A tile is taken in StIdle and its sides are grown in StPrep. Each horizontal edge
// then passes StEdge, StBox and StOut; each slanted edge passes StEdge, StDiff and,
// unless its dx is zero, StDiv in the shared divider that makes one quotient bit per cycle.
// Reset is synchronous; it empties the bounding box and restores register defaults.
// A stalled edge holds in the output register; no new tile is taken until the
// tile's last edge has been taken.
`default_nettype none
module trapezoid_edge_grow_top (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire teg_pkg::coord_type                 req_left_x,
   input  wire teg_pkg::coord_type                 req_right_x,
   input  wire teg_pkg::coord_type                 req_top_left_y,
   input  wire teg_pkg::coord_type                 req_top_right_y,
   input  wire teg_pkg::coord_type                 req_bottom_left_y,
   input  wire teg_pkg::coord_type                 req_bottom_right_y,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output teg_pkg::coord_type                      rsp_edge_x0,
   output teg_pkg::coord_type                      rsp_edge_y0,
   output teg_pkg::coord_type                      rsp_edge_x1,
   output teg_pkg::coord_type                      rsp_edge_y1,
   output teg_pkg::coord_type                      rsp_edge_slope,
   output logic                                    rsp_is_start,
   output logic                                    rsp_last_edge,
   output teg_pkg::coord_type                      rsp_box_min_x,
   output teg_pkg::coord_type                      rsp_box_max_x,
   output teg_pkg::coord_type                      rsp_box_min_y,
   output teg_pkg::coord_type                      rsp_box_max_y,
   input  wire logic                               csr_write_en,
   input  wire logic [teg_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [teg_pkg::CsrDataWidth-1:0]   csr_wdata
);
   import teg_pkg::*;

   typedef enum logic [6:0] {
      StIdle = 7'b0000001,
      StPrep = 7'b0000010,
      StEdge = 7'b0000100,
      StDiff = 7'b0001000,
      StDiv  = 7'b0010000,
      StBox  = 7'b0100000,
      StOut  = 7'b1000000
   } state_type;

   typedef enum logic [1:0] {
      EdgeTopCap   = 2'd0,
      EdgeTopSlant = 2'd1,
      EdgeBotCap   = 2'd2,
      EdgeBotSlant = 2'd3
   } edge_sel_type;

   // Configuration registers.
   logic [GrowWidth-1:0] grow_ff;
   logic [InfYWidth-1:0] inf_y_ff;
   coord_type            inf_xl_ff;
   coord_type            inf_xr_ff;

   state_type    state_ff, state_in;
   edge_sel_type edge_ff, edge_in;

   coord_type bmin_x_ff, bmin_x_in, bmax_x_ff, bmax_x_in;
   coord_type bmin_y_ff, bmin_y_in, bmax_y_ff, bmax_y_in;

   // Tile as taken in.
   coord_type xl_ff, xr_ff, tl_ff, tr_ff, bl_ff, br_ff;

   // Grown sides and tile shape flags.
   coord_type xl_m_ff, xl_p_ff, xr_m_ff, xr_p_ff;
   coord_type tl_p_ff, tr_p_ff, bl_m_ff, br_m_ff;
   coord_type fx0_ff, fx1_ff, fty_ff, fby_ff;
   logic      top_flat_ff, top_lhi_ff, bot_flat_ff, bot_lhi_ff;
   coord_type xl_m_in, xl_p_in, xr_m_in, xr_p_in;
   coord_type tl_p_in, tr_p_in, bl_m_in, br_m_in;

   // Current edge.
   coord_type ex0_ff, ey0_ff, ex1_ff, ey1_ff;
   coord_type ex0_in, ey0_in, ex1_in, ey1_in;
   logic      last_ff, last_in;
   logic      neg_ff;
   coord_type slope_ff;

   // Output register.
   coord_type o_x0_ff, o_y0_ff, o_x1_ff, o_y1_ff, o_slope_ff;
   logic      o_start_ff, o_last_ff;

   coord_type inf_y_pos, inf_y_neg;
   logic signed [MagWidth-1:0] dx, dy;
   mag_type   dx_mag, dy_mag;
   logic      div_start;
   div_stat_type div_stat;
   mag_type   div_quo;
   logic signed [SumWidth-1:0] quo_signed;
   coord_type slope_div;
   logic      req_take, rsp_take;

   assign inf_y_pos = coord_type'({{(CoordWidth-InfYWidth){1'b0}}, inf_y_ff});
   assign inf_y_neg = coord_type'(CoordWidth'(0) - inf_y_pos);

   assign req_take = req_valid & (state_ff == StIdle);
   assign rsp_take = (state_ff == StOut) & ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         grow_ff   <= '0;
         inf_y_ff  <= {InfYWidth{1'b1}};
         inf_xl_ff <= CoordMin;
         inf_xr_ff <= CoordMax;
      end else if (csr_write_en) begin
         case (csr_index)
            CsrGrowAmount: grow_ff   <= csr_wdata[GrowWidth-1:0];
            CsrInfY:       inf_y_ff  <= csr_wdata[InfYWidth-1:0];
            CsrInfXLeft:   inf_xl_ff <= coord_type'(csr_wdata[CoordWidth-1:0]);
            CsrInfXRight:  inf_xr_ff <= coord_type'(csr_wdata[CoordWidth-1:0]);
            default: begin
            end
         endcase
      end
   end

   // Grown sides, computed once per tile.
   always_comb begin
      xl_m_in = grow_coord(xl_ff, grow_ff, 1'b1);
      xl_p_in = grow_coord(xl_ff, grow_ff, 1'b0);
      xr_m_in = grow_coord(xr_ff, grow_ff, 1'b1);
      xr_p_in = grow_coord(xr_ff, grow_ff, 1'b0);
      tl_p_in = grow_coord(tl_ff, grow_ff, 1'b0);
      tr_p_in = grow_coord(tr_ff, grow_ff, 1'b0);
      bl_m_in = grow_coord(bl_ff, grow_ff, 1'b1);
      br_m_in = grow_coord(br_ff, grow_ff, 1'b1);
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         xl_ff <= req_left_x;
         xr_ff <= req_right_x;
         tl_ff <= req_top_left_y;
         tr_ff <= req_top_right_y;
         bl_ff <= req_bottom_left_y;
         br_ff <= req_bottom_right_y;
      end
      if (state_ff == StPrep) begin
         xl_m_ff     <= xl_m_in;
         xl_p_ff     <= xl_p_in;
         xr_m_ff     <= xr_m_in;
         xr_p_ff     <= xr_p_in;
         tl_p_ff     <= tl_p_in;
         tr_p_ff     <= tr_p_in;
         bl_m_ff     <= bl_m_in;
         br_m_ff     <= br_m_in;
         // Sentinels stay put on flat sides only.
         fx0_ff      <= (xl_ff == inf_xl_ff) ? xl_ff : xl_m_in;
         fx1_ff      <= (xr_ff == inf_xr_ff) ? xr_ff : xr_p_in;
         fty_ff      <= (tl_ff == inf_y_pos) ? tl_ff : tl_p_in;
         fby_ff      <= (bl_ff == inf_y_neg) ? bl_ff : bl_m_in;
         top_flat_ff <= (tl_ff == tr_ff);
         top_lhi_ff  <= (tl_ff > tr_ff);
         bot_flat_ff <= (bl_ff == br_ff);
         bot_lhi_ff  <= (bl_ff > br_ff);
      end
   end

   // Endpoints of the selected edge.
   always_comb begin
      ex0_in = xl_m_ff;
      ey0_in = tl_p_ff;
      ex1_in = xl_p_ff;
      ey1_in = tl_p_ff;
      last_in = 1'b0;
      case (edge_ff)
         EdgeTopCap: begin
            if (top_flat_ff) begin
               ex0_in = fx0_ff; ey0_in = fty_ff; ex1_in = fx1_ff; ey1_in = fty_ff;
            end else if (top_lhi_ff) begin
               ex0_in = xl_m_ff; ey0_in = tl_p_ff; ex1_in = xl_p_ff; ey1_in = tl_p_ff;
            end else begin
               ex0_in = xr_m_ff; ey0_in = tr_p_ff; ex1_in = xr_p_ff; ey1_in = tr_p_ff;
            end
         end
         EdgeTopSlant: begin
            if (top_lhi_ff) begin
               ex0_in = xl_p_ff; ey0_in = tl_p_ff; ex1_in = xr_p_ff; ey1_in = tr_p_ff;
            end else begin
               ex0_in = xl_m_ff; ey0_in = tl_p_ff; ex1_in = xr_m_ff; ey1_in = tr_p_ff;
            end
         end
         EdgeBotCap: begin
            last_in = bot_flat_ff;
            if (bot_flat_ff) begin
               ex0_in = fx0_ff; ey0_in = fby_ff; ex1_in = fx1_ff; ey1_in = fby_ff;
            end else if (bot_lhi_ff) begin
               ex0_in = xr_m_ff; ey0_in = br_m_ff; ex1_in = xr_p_ff; ey1_in = br_m_ff;
            end else begin
               ex0_in = xl_m_ff; ey0_in = bl_m_ff; ex1_in = xl_p_ff; ey1_in = bl_m_ff;
            end
         end
         EdgeBotSlant: begin
            last_in = 1'b1;
            if (bot_lhi_ff) begin
               ex0_in = xl_m_ff; ey0_in = bl_m_ff; ex1_in = xr_m_ff; ey1_in = br_m_ff;
            end else begin
               ex0_in = xl_p_ff; ey0_in = bl_m_ff; ex1_in = xr_p_ff; ey1_in = br_m_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Slope operands and the signed, saturated quotient.
   always_comb begin
      dx = {ex1_ff[CoordWidth-1], ex1_ff} - {ex0_ff[CoordWidth-1], ex0_ff};
      dy = {ey1_ff[CoordWidth-1], ey1_ff} - {ey0_ff[CoordWidth-1], ey0_ff};
      dx_mag = dx[MagWidth-1] ? mag_type'(-dx) : mag_type'(dx);
      dy_mag = dy[MagWidth-1] ? mag_type'(-dy) : mag_type'(dy);
      quo_signed = neg_ff ? (SumWidth'(0) - {1'b0, div_quo}) : {1'b0, div_quo};
      slope_div  = sat_coord(quo_signed);
   end

   assign div_start = (state_ff == StDiff) && (dx != '0);

   teg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dy_mag),
      .divisor  (dx_mag),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   // Bounding box after the current edge; sentinel values leave it alone.
   always_comb begin
      bmin_x_in = bmin_x_ff;
      bmax_x_in = bmax_x_ff;
      bmin_y_in = bmin_y_ff;
      bmax_y_in = bmax_y_ff;
      if (ex0_ff < bmin_x_ff && ex0_ff != inf_xl_ff) bmin_x_in = ex0_ff;
      if (ex1_ff > bmax_x_ff && ex1_ff != inf_xr_ff) bmax_x_in = ex1_ff;
      if (ey0_ff < bmin_y_in && ey0_ff != inf_y_neg) bmin_y_in = ey0_ff;
      if (ey0_ff > bmax_y_in && ey0_ff != inf_y_pos) bmax_y_in = ey0_ff;
      if (ey1_ff < bmin_y_in && ey1_ff != inf_y_neg) bmin_y_in = ey1_ff;
      if (ey1_ff > bmax_y_in && ey1_ff != inf_y_pos) bmax_y_in = ey1_ff;
   end

   always_comb begin
      state_in = state_ff;
      edge_in  = edge_ff;
      case (state_ff)
         StIdle: begin
            if (req_take) begin
               state_in = StPrep;
               edge_in  = EdgeTopCap;
            end
         end
         StPrep: state_in = StEdge;
         StEdge: state_in = edge_ff[0] ? StDiff : StBox;
         StDiff: state_in = (dx != '0) ? StDiv : StBox;
         StDiv:  state_in = div_stat.done ? StBox : StDiv;
         StBox:  state_in = StOut;
         StOut: begin
            if (rsp_take) begin
               if (last_ff) begin
                  state_in = StIdle;
               end else begin
                  state_in = StEdge;
                  case (edge_ff)
                     EdgeTopCap:   edge_in = top_flat_ff ? EdgeBotCap : EdgeTopSlant;
                     EdgeTopSlant: edge_in = EdgeBotCap;
                     EdgeBotCap:   edge_in = EdgeBotSlant;
                     default:      edge_in = EdgeBotSlant;
                  endcase
               end
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= StIdle;
         edge_ff   <= EdgeTopCap;
         bmin_x_ff <= CoordMax;
         bmax_x_ff <= CoordMin;
         bmin_y_ff <= CoordMax;
         bmax_y_ff <= CoordMin;
      end else begin
         state_ff <= state_in;
         edge_ff  <= edge_in;
         if (state_ff == StBox) begin
            bmin_x_ff <= bmin_x_in;
            bmax_x_ff <= bmax_x_in;
            bmin_y_ff <= bmin_y_in;
            bmax_y_ff <= bmax_y_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == StEdge) begin
         ex0_ff   <= ex0_in;
         ey0_ff   <= ey0_in;
         ex1_ff   <= ex1_in;
         ey1_ff   <= ey1_in;
         last_ff  <= last_in;
         slope_ff <= '0;
      end
      if (state_ff == StDiff) begin
         neg_ff <= dx[MagWidth-1] ^ dy[MagWidth-1];
      end
      if (state_ff == StDiv && div_stat.done) begin
         slope_ff <= slope_div;
      end
      if (state_ff == StBox) begin
         o_x0_ff    <= ex0_ff;
         o_y0_ff    <= ey0_ff;
         o_x1_ff    <= ex1_ff;
         o_y1_ff    <= ey1_ff;
         o_slope_ff <= slope_ff;
         o_start_ff <= edge_ff[1];
         o_last_ff  <= last_ff;
      end
   end

   assign req_stall      = (state_ff != StIdle);
   assign rsp_valid      = (state_ff == StOut);
   assign rsp_edge_x0    = o_x0_ff;
   assign rsp_edge_y0    = o_y0_ff;
   assign rsp_edge_x1    = o_x1_ff;
   assign rsp_edge_y1    = o_y1_ff;
   assign rsp_edge_slope = o_slope_ff;
   assign rsp_is_start   = o_start_ff;
   assign rsp_last_edge  = o_last_ff;
   assign rsp_box_min_x  = bmin_x_ff;
   assign rsp_box_max_x  = bmax_x_ff;
   assign rsp_box_min_y  = bmin_y_ff;
   assign rsp_box_max_y  = bmax_y_ff;

endmodule
`default_nettype wire

// ----- rtl/teg_checker.sv -----
// Port-level checker for the trapezoid edge grower and its bind to the top level.
`default_nettype none
`include "trapezoid_edge_grow_top_defines.svh"
module teg_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire teg_pkg::coord_type rsp_edge_x0,
   input wire teg_pkg::coord_type rsp_edge_y0,
   input wire teg_pkg::coord_type rsp_edge_y1,
   input wire teg_pkg::coord_type rsp_edge_slope,
   input wire logic               rsp_is_start,
   input wire logic               rsp_last_edge
);
   import teg_pkg::*;

   // A stalled edge keeps its endpoints.
   `TEG_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_edge_x0) && $stable(rsp_edge_y0))
   // No new tile is taken while an edge waits at the output.
   `TEG_ASSERT_NOW(a_busy_while_out, rsp_valid, req_stall)
   // A tile always ends with a bottom edge.
   `TEG_ASSERT_NOW(a_last_is_bottom, rsp_valid && rsp_last_edge, rsp_is_start)
   // An edge with equal end heights has no slope.
   `TEG_ASSERT_NOW(a_flat_slope, rsp_valid && (rsp_edge_y0 == rsp_edge_y1), rsp_edge_slope == '0)
   // Once a tile is taken the block is busy on the next cycle.
   `TEG_ASSERT_NEXT(a_busy_after_take, req_valid && !req_stall, req_stall)

endmodule

bind trapezoid_edge_grow_top teg_checker u_teg_checker (.*);
`default_nettype wire

// ----- dv/teg_edge_checker.sv -----
// Checker for the trapezoid edge grower: predicts the edges of every tile and compares them.
module teg_edge_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic                              req_stall,
   input  wire teg_pkg::coord_type                req_left_x,
   input  wire teg_pkg::coord_type                req_right_x,
   input  wire teg_pkg::coord_type                req_top_left_y,
   input  wire teg_pkg::coord_type                req_top_right_y,
   input  wire teg_pkg::coord_type                req_bottom_left_y,
   input  wire teg_pkg::coord_type                req_bottom_right_y,
   input  wire logic                              rsp_valid,
   input  wire logic                              rsp_stall,
   input  wire teg_pkg::coord_type                rsp_edge_x0,
   input  wire teg_pkg::coord_type                rsp_edge_y0,
   input  wire teg_pkg::coord_type                rsp_edge_x1,
   input  wire teg_pkg::coord_type                rsp_edge_y1,
   input  wire teg_pkg::coord_type                rsp_edge_slope,
   input  wire logic                              rsp_is_start,
   input  wire logic                              rsp_last_edge,
   input  wire teg_pkg::coord_type                rsp_box_min_x,
   input  wire teg_pkg::coord_type                rsp_box_max_x,
   input  wire teg_pkg::coord_type                rsp_box_min_y,
   input  wire teg_pkg::coord_type                rsp_box_max_y,
   input  wire logic                              csr_write_en,
   input  wire logic [teg_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [teg_pkg::CsrDataWidth-1:0]  csr_wdata,
   output int                                     fail_count,
   output int                                     pending
);
   import teg_pkg::*;

   typedef struct {
      coord_type x0;
      coord_type y0;
      coord_type x1;
      coord_type y1;
      coord_type slope;
      logic      is_start;
      logic      last_edge;
      coord_type min_x;
      coord_type max_x;
      coord_type min_y;
      coord_type max_y;
   } tile_edge_type;

   localparam longint CoordHi = CoordMax;
   localparam longint CoordLo = CoordMin;

   tile_edge_type expected_edges[$];
   tile_edge_type want;
   int            mismatches = 0;

   longint grow_amt;
   longint inf_y_val;
   longint inf_xl;
   longint inf_xr;
   longint box_lo_x;
   longint box_hi_x;
   longint box_lo_y;
   longint box_hi_y;

   assign fail_count = mismatches;

   function automatic longint clamp(longint v);
      if (v > CoordHi) begin
         return CoordHi;
      end else if (v < CoordLo) begin
         return CoordLo;
      end
      return v;
   endfunction

   // Saturates the endpoints, works out the slope, widens the box and queues the edge.
   function automatic void add_edge(longint x0, longint y0, longint x1, longint y1,
                                    bit sloped, bit start, bit last);
      tile_edge_type e;
      longint        slope;
      x0 = clamp(x0);
      y0 = clamp(y0);
      x1 = clamp(x1);
      y1 = clamp(y1);
      slope = 0;
      if (sloped && x1 != x0) slope = clamp((y1 - y0) / (x1 - x0));
      if (x0 < box_lo_x && x0 != inf_xl) box_lo_x = x0;
      if (x1 > box_hi_x && x1 != inf_xr) box_hi_x = x1;
      if (y0 < box_lo_y && y0 != -inf_y_val) box_lo_y = y0;
      if (y0 > box_hi_y && y0 != inf_y_val) box_hi_y = y0;
      if (y1 < box_lo_y && y1 != -inf_y_val) box_lo_y = y1;
      if (y1 > box_hi_y && y1 != inf_y_val) box_hi_y = y1;
      e.x0        = x0[CoordWidth-1:0];
      e.y0        = y0[CoordWidth-1:0];
      e.x1        = x1[CoordWidth-1:0];
      e.y1        = y1[CoordWidth-1:0];
      e.slope     = slope[CoordWidth-1:0];
      e.is_start  = start;
      e.last_edge = last;
      e.min_x     = box_lo_x[CoordWidth-1:0];
      e.max_x     = box_hi_x[CoordWidth-1:0];
      e.min_y     = box_lo_y[CoordWidth-1:0];
      e.max_y     = box_hi_y[CoordWidth-1:0];
      expected_edges.push_back(e);
   endfunction

   // Top edges come first; the bottom side always supplies the tile's last edge.
   function automatic void predict_tile_edges(coord_type xl_in, coord_type xr_in,
                                              coord_type tl_in, coord_type tr_in,
                                              coord_type bl_in, coord_type br_in);
      longint xl, xr, tl, tr, bl, br, g, lx, rx, y;
      xl = xl_in;
      xr = xr_in;
      tl = tl_in;
      tr = tr_in;
      bl = bl_in;
      br = br_in;
      g  = grow_amt;
      if (tl == tr) begin
         lx = (xl != inf_xl) ? xl - g : xl;
         rx = (xr != inf_xr) ? xr + g : xr;
         y  = (tl != inf_y_val) ? clamp(tl + g) : tl;
         add_edge(lx, y, rx, y, 1'b0, 1'b0, 1'b0);
      end else if (tl > tr) begin
         add_edge(xl - g, tl + g, xl + g, tl + g, 1'b0, 1'b0, 1'b0);
         add_edge(xl + g, tl + g, xr + g, tr + g, 1'b1, 1'b0, 1'b0);
      end else begin
         add_edge(xr - g, tr + g, xr + g, tr + g, 1'b0, 1'b0, 1'b0);
         add_edge(xl - g, tl + g, xr - g, tr + g, 1'b1, 1'b0, 1'b0);
      end
      if (bl == br) begin
         lx = (xl != inf_xl) ? xl - g : xl;
         rx = (xr != inf_xr) ? xr + g : xr;
         y  = (bl != -inf_y_val) ? clamp(bl - g) : bl;
         add_edge(lx, y, rx, y, 1'b0, 1'b1, 1'b1);
      end else if (bl > br) begin
         add_edge(xr - g, br - g, xr + g, br - g, 1'b0, 1'b1, 1'b0);
         add_edge(xl - g, bl - g, xr - g, br - g, 1'b1, 1'b1, 1'b1);
      end else begin
         add_edge(xl - g, bl - g, xl + g, bl - g, 1'b0, 1'b1, 1'b0);
         add_edge(xl + g, bl - g, xr + g, br - g, 1'b1, 1'b1, 1'b1);
      end
   endfunction

   function automatic void check_field(string name, longint expected, longint actual);
      if (expected != actual) begin
         $display("%0t: edge field %s expected %0d actual %0d",
                  $time, name, expected, actual);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         grow_amt  = 0;
         inf_y_val = CoordHi;
         inf_xl    = CoordLo;
         inf_xr    = CoordHi;
         box_lo_x  = CoordHi;
         box_hi_x  = CoordLo;
         box_lo_y  = CoordHi;
         box_hi_y  = CoordLo;
         expected_edges.delete();
         pending <= 0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CsrGrowAmount: grow_amt  = csr_wdata[GrowWidth-1:0];
               CsrInfY:       inf_y_val = csr_wdata[InfYWidth-1:0];
               CsrInfXLeft:   inf_xl    = $signed(csr_wdata);
               CsrInfXRight:  inf_xr    = $signed(csr_wdata);
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predict_tile_edges(req_left_x, req_right_x, req_top_left_y, req_top_right_y,
                               req_bottom_left_y, req_bottom_right_y);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_edges.size() == 0) begin
               $display("%0t: edge expected none actual x0=%0d y0=%0d x1=%0d y1=%0d",
                        $time, rsp_edge_x0, rsp_edge_y0, rsp_edge_x1, rsp_edge_y1);
               mismatches++;
            end else begin
               want = expected_edges.pop_front();
               check_field("x0", want.x0, rsp_edge_x0);
               check_field("y0", want.y0, rsp_edge_y0);
               check_field("x1", want.x1, rsp_edge_x1);
               check_field("y1", want.y1, rsp_edge_y1);
               check_field("slope", want.slope, rsp_edge_slope);
               check_field("is_start", longint'(want.is_start), longint'(rsp_is_start));
               check_field("last_edge", longint'(want.last_edge), longint'(rsp_last_edge));
               check_field("box_min_x", want.min_x, rsp_box_min_x);
               check_field("box_max_x", want.max_x, rsp_box_max_x);
               check_field("box_min_y", want.min_y, rsp_box_min_y);
               check_field("box_max_y", want.max_y, rsp_box_max_y);
            end
         end
         pending <= expected_edges.size();
      end
   end

endmodule

// ----- dv/trapezoid_edge_grow_top_test.sv -----
// Testbench top for the trapezoid edge grower: clock, reset, stimulus and verdict.
module trapezoid_edge_grow_top_test;
   import teg_pkg::*;

   logic                     clock              = 1'b0;
   logic                     reset              = 1'b1;
   logic                     req_valid          = 1'b0;
   logic                     req_stall;
   coord_type                req_left_x         = '0;
   coord_type                req_right_x        = '0;
   coord_type                req_top_left_y     = '0;
   coord_type                req_top_right_y    = '0;
   coord_type                req_bottom_left_y  = '0;
   coord_type                req_bottom_right_y = '0;
   logic                     rsp_valid;
   logic                     rsp_stall          = 1'b0;
   coord_type                rsp_edge_x0;
   coord_type                rsp_edge_y0;
   coord_type                rsp_edge_x1;
   coord_type                rsp_edge_y1;
   coord_type                rsp_edge_slope;
   logic                     rsp_is_start;
   logic                     rsp_last_edge;
   coord_type                rsp_box_min_x;
   coord_type                rsp_box_max_x;
   coord_type                rsp_box_min_y;
   coord_type                rsp_box_max_y;
   logic                     csr_write_en       = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index          = '0;
   logic [CsrDataWidth-1:0]  csr_wdata          = '0;
   int                       fail_count;
   int                       pending;

   // Copy of the sentinels in force, so random tiles can land on them.
   coord_type cur_inf_y  = CoordMax;
   coord_type cur_inf_xl = CoordMin;
   coord_type cur_inf_xr = CoordMax;
   logic      quiet      = 1'b0;
   int        stall_hold = 0;

   trapezoid_edge_grow_top DUT (.*);

   teg_edge_checker edge_check (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(15, 60);
   endfunction

   always @(posedge clock) begin
      if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         rsp_stall  <= ($urandom_range(0, 99) < 35);
         stall_hold <= idle_span();
      end
   end

   task automatic send_tile(coord_type xl, coord_type xr, coord_type tl, coord_type tr,
                            coord_type bl, coord_type br);
      int gap;
      req_valid          <= 1'b1;
      req_left_x         <= xl;
      req_right_x        <= xr;
      req_top_left_y     <= tl;
      req_top_right_y    <= tr;
      req_bottom_left_y  <= bl;
      req_bottom_right_y <= br;
      do @(posedge clock); while (req_stall);
      gap = quiet ? 0 : idle_span();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Holds off the sender until every predicted edge has been taken.
   task automatic drain_tiles();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Upper bits above a register's width are filled with noise; the block must drop them.
   task automatic set_config(logic [GrowWidth-1:0] g, logic [InfYWidth-1:0] iy,
                             coord_type ixl, coord_type ixr);
      logic [CsrDataWidth-1:0] w;
      w = $urandom;
      w[GrowWidth-1:0] = g;
      csr_write_en <= 1'b1;
      csr_index    <= CsrGrowAmount;
      csr_wdata    <= w;
      @(posedge clock);
      w = $urandom;
      w[InfYWidth-1:0] = iy;
      csr_index <= CsrInfY;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CsrInfXLeft;
      csr_wdata <= ixl;
      @(posedge clock);
      csr_index <= CsrInfXRight;
      csr_wdata <= ixr;
      @(posedge clock);
      csr_write_en <= 1'b0;
      cur_inf_y  = {1'b0, iy};
      cur_inf_xl = ixl;
      cur_inf_xr = ixr;
   endtask

   task automatic random_config();
      logic [CsrDataWidth-1:0] w;
      logic [GrowWidth-1:0]    g;
      logic [InfYWidth-1:0]    iy;
      coord_type               ixl;
      coord_type               ixr;
      w = $urandom;
      case ($urandom_range(0, 3))
         0:       g = '0;
         1:       g = GrowWidth'($urandom_range(1, 20));
         2:       g = w[GrowWidth-1:0];
         default: g = '1;
      endcase
      w = $urandom;
      case ($urandom_range(0, 2))
         0:       iy = '1;
         1:       iy = InfYWidth'($urandom_range(0, 100));
         default: iy = w[InfYWidth-1:0];
      endcase
      case ($urandom_range(0, 2))
         0:       ixl = CoordMin;
         1:       ixl = coord_type'($urandom_range(0, 200)) - 100;
         default: ixl = coord_type'($urandom);
      endcase
      case ($urandom_range(0, 2))
         0:       ixr = CoordMax;
         1:       ixr = coord_type'($urandom_range(0, 200)) - 100;
         default: ixr = coord_type'($urandom);
      endcase
      set_config(g, iy, ixl, ixr);
   endtask

   function automatic coord_type rand_coord(int wide_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < wide_pct) return coord_type'($urandom);
      if (r < wide_pct + 5) return $urandom_range(0, 1) ? CoordMax : CoordMin;
      return coord_type'($urandom_range(0, 200)) - 100;
   endfunction

   // Flat sides and sentinel hits are forced often enough to be seen in every phase.
   task automatic send_random_tile(int wide_pct);
      coord_type xl, xr, tl, tr, bl, br;
      xl = rand_coord(wide_pct);
      xr = rand_coord(wide_pct);
      tl = rand_coord(wide_pct);
      tr = rand_coord(wide_pct);
      bl = rand_coord(wide_pct);
      br = rand_coord(wide_pct);
      if ($urandom_range(0, 2) == 0) tr = tl;
      if ($urandom_range(0, 2) == 0) br = bl;
      if ($urandom_range(0, 9) == 0) xl = cur_inf_xl;
      if ($urandom_range(0, 9) == 0) xr = cur_inf_xr;
      if ($urandom_range(0, 9) == 0) begin
         tl = cur_inf_y;
         tr = cur_inf_y;
      end
      if ($urandom_range(0, 9) == 0) begin
         bl = -cur_inf_y;
         br = -cur_inf_y;
      end
      send_tile(xl, xr, tl, tr, bl, br);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Register defaults, no growth: every side shape, zero width, reversed and extremes.
      send_tile(0, 10, 20, 20, 0, 0);
      send_tile(0, 100, 50, 30, 10, -5);
      send_tile(-40, 60, 30, 50, -20, 10);
      send_tile(5, 5, 10, 20, -3, -8);
      send_tile(100, -100, 0, 50, -50, -10);
      send_tile(0, 1, CoordMin, CoordMax, CoordMax, CoordMin);
      send_tile(CoordMin, CoordMax, CoordMax, CoordMin, CoordMin, CoordMax);
      send_tile(CoordMin, CoordMax, CoordMax, CoordMax, CoordMin + 1, CoordMin + 1);

      // Small growth with near sentinels: flat sides honor them, sloped sides do not.
      drain_tiles();
      set_config(30'd5, 31'd1000, -1000, 1000);
      send_tile(-1000, 1000, 1000, 1000, -1000, -1000);
      send_tile(-999, 999, 999, 999, -999, -999);
      send_tile(-1000, 1000, 1000, 0, -1000, 0);
      send_tile(0, 10, 1000, 1000, 5, 5);
      send_tile(-20, 20, -1000, -1000, 1000, 1000);

      // Largest growth, zero infinity and swapped x sentinels.
      drain_tiles();
      set_config('1, '0, CoordMax, CoordMin);
      send_tile(0, 0, 0, 0, 0, 0);
      send_tile(CoordMin, CoordMax, CoordMax, CoordMax, CoordMin, CoordMin);
      send_tile(CoordMax, CoordMin, 5, 5, -5, -5);
      send_tile(-100, 100, CoordMin + 3, CoordMax - 2, CoordMax, CoordMin);

      for (int ph = 0; ph < 4; ph++) begin
         drain_tiles();
         random_config();
         quiet <= (ph == 1);
         for (int n = 0; n < 50; n++) begin
            send_random_tile(10 + 27 * ph);
            if (ph == 2 && n == 25) drain_tiles();
         end
      end
      quiet <= 1'b0;

      drain_tiles();
      repeat (100) @(posedge clock);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #5000000;
      $display("simulation failed");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/teg_pkg.sv
rtl/teg_div.sv
rtl/trapezoid_edge_grow_top.sv
rtl/teg_checker.sv
dv/teg_edge_checker.sv
dv/trapezoid_edge_grow_top_test.sv
